// File: hdl/qafs_pkg.sv
// Shared types and constants for the quote-aware field splitter.
package qafs_pkg;

    localparam int CHAR_W     = 8;
    localparam int FIELD_W    = 8;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 3;
    localparam int MAX_DELIMS = 4;

    localparam logic [CHAR_W-1:0] CODE_DQUOTE  = 8'd34;
    localparam logic [CHAR_W-1:0] CODE_SQUOTE  = 8'd39;
    localparam logic [CHAR_W-1:0] CODE_LPAREN  = 8'd40;
    localparam logic [CHAR_W-1:0] CODE_RPAREN  = 8'd41;
    localparam logic [CHAR_W-1:0] CODE_LSQUARE = 8'd91;
    localparam logic [CHAR_W-1:0] CODE_RSQUARE = 8'd93;
    localparam logic [CHAR_W-1:0] CODE_LCURLY  = 8'd123;
    localparam logic [CHAR_W-1:0] CODE_RCURLY  = 8'd125;

    localparam logic [CHAR_W-1:0]  DELIM_RESET [MAX_DELIMS] = '{8'd44, 8'd59, 8'd0, 8'd0};
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 3'd1;
    localparam logic               BRACKET_RESET = 1'b1;
    localparam logic [FIELD_W-1:0] FIELD_MAX     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM0  = 3'd0,
        CFG_DELIM1  = 3'd1,
        CFG_DELIM2  = 3'd2,
        CFG_DELIM3  = 3'd3,
        CFG_COUNT   = 3'd4,
        CFG_BRACKET = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              is_quote;
        logic              is_open;
        logic              is_close;
        logic              bracket_on;
        logic              found;
        logic [IDX_W-1:0]  idx;
    } t_item;

endpackage

// File: hdl/qafs_front.sv
// Front part: configuration registers and classification of each incoming character.
module qafs_front #(
    parameter int NUM_DELIMS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [qafs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qafs_pkg::CHAR_W-1:0]       i_cfg_data,
    input  logic [qafs_pkg::CHAR_W-1:0]       i_char,
    input  logic                              i_last,
    output qafs_pkg::t_item                   o_item
);

    logic [qafs_pkg::CHAR_W-1:0]  r_delim [NUM_DELIMS];
    logic [qafs_pkg::COUNT_W-1:0] r_count;
    logic                         r_bracket;
    logic [NUM_DELIMS-1:0]        w_hit;

    for (genvar g = 0; g < NUM_DELIMS; g++) begin : g_delim
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_delim[g] <= qafs_pkg::DELIM_RESET[g];
            end else if (i_cfg_valid && i_cfg_index == qafs_pkg::CFG_IDX_W'(g)) begin
                r_delim[g] <= i_cfg_data;
            end
        end

        assign w_hit[g] = (qafs_pkg::COUNT_W'(g) < r_count) && (r_delim[g] == i_char);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= qafs_pkg::COUNT_RESET;
            r_bracket <= qafs_pkg::BRACKET_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qafs_pkg::CFG_COUNT: begin
                    r_count <= i_cfg_data[qafs_pkg::COUNT_W-1:0];
                end
                qafs_pkg::CFG_BRACKET: begin
                    r_bracket <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_item            = '0;
        o_item.char_code  = i_char;
        o_item.last       = i_last;
        o_item.is_quote   = (i_char == qafs_pkg::CODE_DQUOTE) ||
                            (i_char == qafs_pkg::CODE_SQUOTE);
        o_item.is_open    = r_bracket && ((i_char == qafs_pkg::CODE_LPAREN) ||
                            (i_char == qafs_pkg::CODE_LSQUARE) ||
                            (i_char == qafs_pkg::CODE_LCURLY));
        o_item.is_close   = r_bracket && ((i_char == qafs_pkg::CODE_RPAREN) ||
                            (i_char == qafs_pkg::CODE_RSQUARE) ||
                            (i_char == qafs_pkg::CODE_RCURLY));
        o_item.bracket_on = r_bracket;
        o_item.found      = |w_hit;
        for (int k = NUM_DELIMS - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_item.idx = qafs_pkg::IDX_W'(k);
            end
        end
    end

endmodule

// File: hdl/qafs_queue.sv
// Two-entry queue between the classifying front part and the state-tracking back part.
module qafs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qafs_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_avail,
    output qafs_pkg::t_item o_item
);

    qafs_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = r_count[1];
    assign o_avail = (r_count != 2'd0);
    assign o_item  = r_mem[r_rp];

endmodule

// File: hdl/qafs_back.sv
// Back part: quote, bracket depth and field count tracking, with the output register.
module qafs_back #(
    parameter int MAX_DEPTH = 127
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  qafs_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [qafs_pkg::CHAR_W-1:0]   o_char_out,
    output logic                          o_is_split,
    output logic [qafs_pkg::IDX_W-1:0]    o_delim_index,
    output logic [qafs_pkg::FIELD_W-1:0]  o_field_number,
    output logic                          o_string_end,
    output logic                          o_depth_saturated
);

    localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
    localparam logic signed [DW-1:0] DMAX = DW'(MAX_DEPTH);
    localparam logic signed [DW-1:0] DMIN = -DMAX;

    logic                          r_in_quote, n_in_quote;
    logic [qafs_pkg::CHAR_W-1:0]   r_open_quote, n_open_quote;
    logic signed [DW-1:0]          r_depth, n_depth;
    logic [qafs_pkg::FIELD_W-1:0]  r_field, n_field;
    logic                          r_valid;
    logic [qafs_pkg::CHAR_W-1:0]   r_char;
    logic                          r_split, n_split;
    logic [qafs_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [qafs_pkg::FIELD_W-1:0]  r_fnum;
    logic                          r_end;
    logic                          r_sat, n_sat;

    assign o_pop = i_avail && (!r_valid || !i_out_stall);

    always_comb begin
        n_in_quote   = r_in_quote;
        n_open_quote = r_open_quote;
        n_depth      = r_depth;
        n_sat        = 1'b0;
        n_split      = 1'b0;
        n_idx        = '0;
        if (r_in_quote && i_item.char_code == r_open_quote) begin
            n_in_quote = 1'b0;
        end else if (!r_in_quote && i_item.is_quote) begin
            n_in_quote   = 1'b1;
            n_open_quote = i_item.char_code;
        end
        if (!n_in_quote) begin
            if (i_item.is_open) begin
                if (r_depth >= DMAX) begin
                    n_sat = 1'b1;
                end else begin
                    n_depth = r_depth + DW'(1);
                end
            end else if (i_item.is_close) begin
                if (r_depth <= DMIN) begin
                    n_sat = 1'b1;
                end else begin
                    n_depth = r_depth - DW'(1);
                end
            end
            if (i_item.found && (!i_item.bracket_on || n_depth == '0)) begin
                n_split = 1'b1;
                n_idx   = i_item.idx;
            end
        end
        n_field = r_field;
        if (n_split && r_field != qafs_pkg::FIELD_MAX) begin
            n_field = r_field + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote   <= 1'b0;
            r_open_quote <= qafs_pkg::CODE_DQUOTE;
            r_depth      <= '0;
            r_field      <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_item.last) begin
                    r_in_quote   <= 1'b0;
                    r_open_quote <= qafs_pkg::CODE_DQUOTE;
                    r_depth      <= '0;
                    r_field      <= '0;
                end else begin
                    r_in_quote   <= n_in_quote;
                    r_open_quote <= n_open_quote;
                    r_depth      <= n_depth;
                    r_field      <= n_field;
                end
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char  <= i_item.char_code;
            r_split <= n_split;
            r_idx   <= n_idx;
            r_fnum  <= r_field;
            r_end   <= i_item.last;
            r_sat   <= n_sat;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_char_out        = r_char;
    assign o_is_split        = r_split;
    assign o_delim_index     = r_idx;
    assign o_field_number    = r_fnum;
    assign o_string_end      = r_end;
    assign o_depth_saturated = r_sat;

    a_depth_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth <= DMAX) && (r_depth >= DMIN))
        else $error("Bracket depth left its bound.");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> !r_in_quote && r_depth == '0 && r_field == '0)
        else $error("State not cleared after the last character.");

    a_split_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_split && !i_item.last && r_field != qafs_pkg::FIELD_MAX
        |=> r_field == $past(r_field) + 1'b1)
        else $error("Field counter did not advance on a split.");

    a_quote_no_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && n_in_quote |=> !r_split && !r_sat)
        else $error("Split or saturation inside a quoted span.");

endmodule

// File: hdl/quote_aware_field_splitter.sv
// Quote-aware field splitter: one character per cycle in and one result per cycle out,
// unless stalled. Each accepted character yields one result, in order, with a split
// flag, the matching delimiter index and the running field number. The block sustains
// one character per clock cycle while the output is not stalled; the limit is the
// update of the quote, depth and field state in the back part for each character. A
// result passes through the two-entry queue and then the output register before it
// becomes valid. Configuration writes are always ready and must be made only while no
// character is in flight.
module quote_aware_field_splitter #(
    parameter int MAX_DEPTH  = 127,
    parameter int NUM_DELIMS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qafs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qafs_pkg::CHAR_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [qafs_pkg::CHAR_W-1:0]       i_char_in,
    input  logic                              i_last_char,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [qafs_pkg::CHAR_W-1:0]       o_char_out,
    output logic                              o_is_split,
    output logic [qafs_pkg::IDX_W-1:0]        o_delim_index,
    output logic [qafs_pkg::FIELD_W-1:0]      o_field_number,
    output logic                              o_string_end,
    output logic                              o_depth_saturated
);

    qafs_pkg::t_item w_front_item;
    qafs_pkg::t_item w_back_item;
    logic            w_full;
    logic            w_avail;
    logic            w_push;
    logic            w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_push      = i_in_valid && !w_full;

    qafs_front #(
        .NUM_DELIMS (NUM_DELIMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (i_char_in),
        .i_last      (i_last_char),
        .o_item      (w_front_item)
    );

    qafs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_avail (w_avail),
        .o_item  (w_back_item)
    );

    qafs_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_avail           (w_avail),
        .i_item            (w_back_item),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_char_out        (o_char_out),
        .o_is_split        (o_is_split),
        .o_delim_index     (o_delim_index),
        .o_field_number    (o_field_number),
        .o_string_end      (o_string_end),
        .o_depth_saturated (o_depth_saturated)
    );

endmodule

// File: verif/qafs_checker.sv
// Checker for the quote-aware field splitter: predicts each result and compares it.
`timescale 1ns / 100ps

module qafs_checker #(
    parameter int MAX_DEPTH  = 127,
    parameter int NUM_DELIMS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [qafs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qafs_pkg::CHAR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [qafs_pkg::CHAR_W-1:0]    i_char_in,
    input  logic                           i_last_char,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [qafs_pkg::CHAR_W-1:0]    i_char_out,
    input  logic                           i_is_split,
    input  logic [qafs_pkg::IDX_W-1:0]     i_delim_index,
    input  logic [qafs_pkg::FIELD_W-1:0]   i_field_number,
    input  logic                           i_string_end,
    input  logic                           i_depth_saturated,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [qafs_pkg::CHAR_W-1:0]  code;
        logic                         split;
        logic [qafs_pkg::IDX_W-1:0]   index;
        logic [qafs_pkg::FIELD_W-1:0] field;
        logic                         tail;
        logic                         sat;
    } t_char_result;

    t_char_result                 char_results[$];

    logic [qafs_pkg::CHAR_W-1:0]  delim_code [qafs_pkg::MAX_DELIMS];
    logic [qafs_pkg::COUNT_W-1:0] delim_count;
    logic                         bracket_on;

    logic                         quoted;
    logic [qafs_pkg::CHAR_W-1:0]  quote_char;
    int                           depth;
    logic [qafs_pkg::FIELD_W-1:0] field_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic void clear_string_state();
        quoted     = 1'b0;
        quote_char = qafs_pkg::CODE_DQUOTE;
        depth      = 0;
        field_cnt  = '0;
    endfunction

    // Advances the split state by one character and returns its result.
    function automatic t_char_result split_char(input logic [qafs_pkg::CHAR_W-1:0] c,
                                                input logic last);
        t_char_result r;
        int           n;
        logic         found;
        r       = '0;
        r.code  = c;
        r.tail  = last;
        r.field = field_cnt;
        found   = 1'b0;
        if (quoted && c == quote_char) begin
            quoted = 1'b0;
        end else if (!quoted && (c == qafs_pkg::CODE_DQUOTE || c == qafs_pkg::CODE_SQUOTE)) begin
            quoted     = 1'b1;
            quote_char = c;
        end
        if (!quoted) begin
            if (bracket_on) begin
                if (c == qafs_pkg::CODE_LPAREN || c == qafs_pkg::CODE_LSQUARE ||
                    c == qafs_pkg::CODE_LCURLY) begin
                    if (depth >= MAX_DEPTH) r.sat = 1'b1;
                    else depth++;
                end else if (c == qafs_pkg::CODE_RPAREN || c == qafs_pkg::CODE_RSQUARE ||
                             c == qafs_pkg::CODE_RCURLY) begin
                    if (depth <= -MAX_DEPTH) r.sat = 1'b1;
                    else depth--;
                end
            end
            n = (delim_count > NUM_DELIMS) ? NUM_DELIMS : int'(delim_count);
            for (int i = 0; i < n; i++) begin
                if (!found && delim_code[i] == c) begin
                    found   = 1'b1;
                    r.index = qafs_pkg::IDX_W'(i);
                end
            end
            if (found && (!bracket_on || depth == 0)) r.split = 1'b1;
            else r.index = '0;
        end
        if (r.split && field_cnt != qafs_pkg::FIELD_MAX) field_cnt++;
        if (last) clear_string_state();
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_char_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < qafs_pkg::MAX_DELIMS; i++) begin
                delim_code[i] = qafs_pkg::DELIM_RESET[i];
            end
            delim_count = qafs_pkg::COUNT_RESET;
            bracket_on  = qafs_pkg::BRACKET_RESET;
            clear_string_state();
            char_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (qafs_pkg::t_cfg_idx'(i_cfg_index))
                    qafs_pkg::CFG_DELIM0:  delim_code[0] = i_cfg_data;
                    qafs_pkg::CFG_DELIM1:  delim_code[1] = i_cfg_data;
                    qafs_pkg::CFG_DELIM2:  delim_code[2] = i_cfg_data;
                    qafs_pkg::CFG_DELIM3:  delim_code[3] = i_cfg_data;
                    qafs_pkg::CFG_COUNT:   delim_count = i_cfg_data[qafs_pkg::COUNT_W-1:0];
                    qafs_pkg::CFG_BRACKET: bracket_on = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (char_results.size() == 0) begin
                    report_mismatch("result with none pending", i_char_out, -1);
                end else begin
                    want = char_results.pop_front();
                    if (i_char_out !== want.code)
                        report_mismatch("char_out", i_char_out, want.code);
                    if (i_is_split !== want.split)
                        report_mismatch("is_split", i_is_split, want.split);
                    if (i_delim_index !== want.index)
                        report_mismatch("delim_index", i_delim_index, want.index);
                    if (i_field_number !== want.field)
                        report_mismatch("field_number", i_field_number, want.field);
                    if (i_string_end !== want.tail)
                        report_mismatch("string_end", i_string_end, want.tail);
                    if (i_depth_saturated !== want.sat)
                        report_mismatch("depth_saturated", i_depth_saturated, want.sat);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                char_results = {char_results, split_char(i_char_in, i_last_char)};
            end
        end
        o_pending = char_results.size();
    end

endmodule

// File: verif/testbench.sv
// Top of the field splitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_DEPTH   = 127;
    localparam int NUM_DELIMS  = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1300;

    localparam logic [qafs_pkg::CHAR_W-1:0] CODE_COMMA   = 8'd44;
    localparam logic [qafs_pkg::CHAR_W-1:0] CODE_SEMI    = 8'd59;
    localparam logic [qafs_pkg::CHAR_W-1:0] CODE_LOWER_A = 8'd97;
    localparam logic [qafs_pkg::CHAR_W-1:0] CODE_NUL     = 8'd0;
    localparam logic [qafs_pkg::CHAR_W-1:0] CODE_TOP     = 8'd255;

    localparam logic [qafs_pkg::CHAR_W-1:0] OPENERS [3] =
        '{qafs_pkg::CODE_LPAREN, qafs_pkg::CODE_LSQUARE, qafs_pkg::CODE_LCURLY};
    localparam logic [qafs_pkg::CHAR_W-1:0] CLOSERS [3] =
        '{qafs_pkg::CODE_RPAREN, qafs_pkg::CODE_RSQUARE, qafs_pkg::CODE_RCURLY};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [qafs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [qafs_pkg::CHAR_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [qafs_pkg::CHAR_W-1:0]    char_in;
    logic                           last_char;
    logic                           out_valid;
    logic                           out_stall;
    logic [qafs_pkg::CHAR_W-1:0]    char_out;
    logic                           is_split;
    logic [qafs_pkg::IDX_W-1:0]     delim_index;
    logic [qafs_pkg::FIELD_W-1:0]   field_number;
    logic                           string_end;
    logic                           depth_saturated;

    int                             fail_count;
    int                             pending;
    int                             cycle_count = 0;
    int                             items_sent = 0;
    int                             stall_left = 0;
    logic                           calm = 1'b1;

    logic [qafs_pkg::CHAR_W-1:0]    cur_delim [qafs_pkg::MAX_DELIMS];
    logic [qafs_pkg::COUNT_W-1:0]   cur_count;
    logic [qafs_pkg::CHAR_W-1:0]    line_buf[$];

    quote_aware_field_splitter #(
        .MAX_DEPTH  (MAX_DEPTH),
        .NUM_DELIMS (NUM_DELIMS)
    ) DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_char_in         (char_in),
        .i_last_char       (last_char),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_char_out        (char_out),
        .o_is_split        (is_split),
        .o_delim_index     (delim_index),
        .o_field_number    (field_number),
        .o_string_end      (string_end),
        .o_depth_saturated (depth_saturated)
    );

    qafs_checker #(
        .MAX_DEPTH  (MAX_DEPTH),
        .NUM_DELIMS (NUM_DELIMS)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_char_in         (char_in),
        .i_last_char       (last_char),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_char_out        (char_out),
        .i_is_split        (is_split),
        .i_delim_index     (delim_index),
        .i_field_number    (field_number),
        .i_string_end      (string_end),
        .i_depth_saturated (depth_saturated),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // The receiver stalls in bursts whose length is drawn from the sender's gap mix, lengthened so every burst stalls.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = idle_len() + 1;
        end
    end

    task automatic send_char(input logic [qafs_pkg::CHAR_W-1:0] c, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_in   = c;
        last_char = last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    function automatic void add_char(input logic [qafs_pkg::CHAR_W-1:0] c);
        line_buf = {line_buf, c};
    endfunction

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input qafs_pkg::t_cfg_idx idx,
                             input logic [qafs_pkg::CHAR_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [qafs_pkg::CHAR_W-1:0] d0,
                                  input logic [qafs_pkg::CHAR_W-1:0] d1,
                                  input logic [qafs_pkg::CHAR_W-1:0] d2,
                                  input logic [qafs_pkg::CHAR_W-1:0] d3,
                                  input logic [qafs_pkg::COUNT_W-1:0] count,
                                  input logic bracket);
        wait_idle();
        write_reg(qafs_pkg::CFG_DELIM0, d0);
        write_reg(qafs_pkg::CFG_DELIM1, d1);
        write_reg(qafs_pkg::CFG_DELIM2, d2);
        write_reg(qafs_pkg::CFG_DELIM3, d3);
        write_reg(qafs_pkg::CFG_COUNT, {5'd0, count});
        write_reg(qafs_pkg::CFG_BRACKET, {7'd0, bracket});
        cur_delim = '{d0, d1, d2, d3};
        cur_count = count;
    endtask

    function automatic logic [qafs_pkg::CHAR_W-1:0] pick_letter();
        return CODE_LOWER_A + qafs_pkg::CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [qafs_pkg::CHAR_W-1:0] pick_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return cur_delim[$urandom_range(0, qafs_pkg::MAX_DELIMS - 1)];
        if (r < 25) return $urandom_range(0, 1) ? qafs_pkg::CODE_DQUOTE : qafs_pkg::CODE_SQUOTE;
        if (r < 40) begin
            if ($urandom_range(0, 1)) return OPENERS[$urandom_range(0, 2)];
            return CLOSERS[$urandom_range(0, 2)];
        end
        if (r < 85) return pick_letter();
        return qafs_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    // Most strings are fields of words, quoted spans, bracket groups or noise runs, joined by
    // configured delimiters or, when none is enabled, by noise; the rest is unstructured noise.
    task automatic build_line();
        int                          nf;
        int                          usable;
        int                          b;
        logic [qafs_pkg::CHAR_W-1:0] q;
        logic [qafs_pkg::CHAR_W-1:0] c;
        line_buf.delete();
        usable = (cur_count > qafs_pkg::MAX_DELIMS) ? qafs_pkg::MAX_DELIMS : int'(cur_count);
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 24)) add_char(pick_noise());
        end else begin
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++) begin
                if (f > 0) begin
                    if (usable > 0) add_char(cur_delim[$urandom_range(0, usable - 1)]);
                    else add_char(pick_noise());
                end
                case ($urandom_range(0, 3))
                    0: begin
                        repeat ($urandom_range(0, 5)) add_char(pick_letter());
                    end
                    1: begin
                        q = $urandom_range(0, 1) ? qafs_pkg::CODE_DQUOTE : qafs_pkg::CODE_SQUOTE;
                        add_char(q);
                        repeat ($urandom_range(0, 6)) begin
                            c = pick_noise();
                            if (c != q) add_char(c);
                        end
                        add_char(q);
                    end
                    2: begin
                        b = $urandom_range(0, 2);
                        add_char(OPENERS[b]);
                        repeat ($urandom_range(0, 5)) begin
                            c = pick_noise();
                            if (c != qafs_pkg::CODE_DQUOTE && c != qafs_pkg::CODE_SQUOTE) begin
                                add_char(c);
                            end
                        end
                        add_char(CLOSERS[b]);
                    end
                    default: begin
                        repeat ($urandom_range(1, 6)) add_char(pick_noise());
                    end
                endcase
            end
        end
        if (line_buf.size() == 0) add_char(pick_letter());
    endtask

    task automatic random_lines(input int amount);
        int start;
        start = items_sent;
        while (items_sent - start < amount) begin
            calm = ($urandom_range(0, 4) == 0);
            build_line();
            send_line();
        end
        calm = 1'b0;
    endtask

    task automatic repeat_line(input logic [qafs_pkg::CHAR_W-1:0] c, input int n,
                               input logic [qafs_pkg::CHAR_W-1:0] tail);
        line_buf.delete();
        repeat (n) add_char(c);
        add_char(tail);
        send_line();
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        char_in   = '0;
        last_char = 1'b0;
        out_stall = 1'b0;
        cur_delim = qafs_pkg::DELIM_RESET;
        cur_count = qafs_pkg::COUNT_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        apply_settings(CODE_COMMA, CODE_SEMI, CODE_NUL, CODE_COMMA, 3'd4, 1'b1);
        calm = 1'b0;
        line_buf = '{pick_letter(), CODE_COMMA, qafs_pkg::CODE_DQUOTE, CODE_COMMA,
                     qafs_pkg::CODE_SQUOTE, qafs_pkg::CODE_DQUOTE, qafs_pkg::CODE_SQUOTE,
                     qafs_pkg::CODE_DQUOTE, qafs_pkg::CODE_SQUOTE, CODE_SEMI,
                     qafs_pkg::CODE_LPAREN, CODE_COMMA, qafs_pkg::CODE_RPAREN,
                     qafs_pkg::CODE_RSQUARE, CODE_COMMA, qafs_pkg::CODE_LSQUARE,
                     qafs_pkg::CODE_LCURLY, qafs_pkg::CODE_RCURLY, CODE_NUL, CODE_TOP};
        send_line();
        line_buf = '{CODE_COMMA};
        send_line();

        random_lines(300);

        apply_settings(qafs_pkg::CODE_LPAREN, qafs_pkg::CODE_DQUOTE, qafs_pkg::CODE_RPAREN,
                       CODE_TOP, 3'd7, 1'b0);
        random_lines(150);

        apply_settings(CODE_NUL, CODE_TOP, CODE_TOP, CODE_NUL, 3'd3, 1'b1);
        repeat_line(qafs_pkg::CODE_LCURLY, MAX_DEPTH + 3, CODE_COMMA);
        repeat_line(qafs_pkg::CODE_RSQUARE, MAX_DEPTH + 3, CODE_NUL);
        repeat_line(CODE_NUL, 258, pick_letter());
        random_lines(80);

        apply_settings(CODE_COMMA, CODE_SEMI, qafs_pkg::CODE_LSQUARE, qafs_pkg::CODE_SQUOTE,
                       3'd0, 1'b1);
        random_lines(80);

        while (items_sent < ITEM_TARGET) begin
            apply_settings(qafs_pkg::CHAR_W'($urandom_range(0, 255)), pick_noise(),
                           pick_noise(), qafs_pkg::CHAR_W'($urandom_range(0, 255)),
                           qafs_pkg::COUNT_W'($urandom_range(0, 7)),
                           1'($urandom_range(0, 1)));
            random_lines(120);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: quote_aware_field_splitter.f
hdl/qafs_pkg.sv
hdl/qafs_front.sv
hdl/qafs_queue.sv
hdl/qafs_back.sv
hdl/quote_aware_field_splitter.sv
verif/qafs_checker.sv
verif/testbench.sv
